@@ hdl/vbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_pkg
// Types and timing constants shared by the video beam timer modules.
// ----------------------------------------------------------------------------
package vbt_pkg;

  localparam int unsigned DotW  = 11;
  localparam int unsigned LineW = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  localparam logic [DotW-1:0]  DotsPerLine       = 11'd1364;
  localparam logic [LineW-1:0] LinesPerFrame     = 9'd262;
  localparam logic [LineW-1:0] VblankLine        = 9'd225;
  localparam logic [LineW-1:0] VblankLineOvscan  = 9'd240;
  localparam logic [DotW-1:0]  HdmaDot           = 11'd1024;
  localparam logic [DotW-1:0]  DotStep           = 11'd2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegVIrqEn   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHIrqEn   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVTimer   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHTimer   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNmiEn    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAutoJoy  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOverscan = 3'd6;

  typedef struct packed {
    logic             v_irq_enable;
    logic             h_irq_enable;
    logic [LineW-1:0] v_timer;
    logic [8:0]       h_timer;
    logic             nmi_enable;
    logic             auto_joy_enable;
    logic             overscan_mode;
  } cfg_t;

  typedef struct packed {
    logic clear_irq_flag;
    logic clear_nmi_flag;
  } in_item_t;

  typedef struct packed {
    logic [DotW-1:0]  dot_position;
    logic [LineW-1:0] line_position;
    logic             irq_request;
    logic             irq_flag;
    logic             nmi_request;
    logic             nmi_flag;
    logic             vblank_active;
    logic             vblank_start_pulse;
    logic             hdma_rearm_pulse;
    logic             hdma_line_pulse;
    logic             joy_restart_pulse;
    logic             frame_done;
  } out_item_t;

  typedef struct packed {
    logic [DotW-1:0]  dot_count;
    logic [LineW-1:0] line_count;
    logic             in_vblank;
    logic             in_nmi;
    logic             in_irq;
  } beam_state_t;

endpackage
`default_nettype wire

@@ hdl/vbt_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module vbt_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [vbt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [vbt_pkg::CfgDataW-1:0] cfg_data_i,
  output vbt_pkg::cfg_t                     cfg_o
);
  import vbt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVIrqEn:   cfg_d.v_irq_enable    = cfg_data_i[0];
        RegHIrqEn:   cfg_d.h_irq_enable    = cfg_data_i[0];
        RegVTimer:   cfg_d.v_timer         = cfg_data_i[LineW-1:0];
        RegHTimer:   cfg_d.h_timer         = cfg_data_i[8:0];
        RegNmiEn:    cfg_d.nmi_enable      = cfg_data_i[0];
        RegAutoJoy:  cfg_d.auto_joy_enable = cfg_data_i[0];
        RegOverscan: cfg_d.overscan_mode   = cfg_data_i[0];
        default:     cfg_d = cfg_q; // unused index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{v_irq_enable: 1'b0, h_irq_enable: 1'b0, v_timer: 9'd511,
                 h_timer: 9'd511, nmi_enable: 1'b0, auto_joy_enable: 1'b0,
                 overscan_mode: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hdl/vbt_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_step
// One beam tick: compares, frame/vblank events, position advance.
// ----------------------------------------------------------------------------
module vbt_step (
  input  wire vbt_pkg::cfg_t        cfg_i,
  input  wire vbt_pkg::beam_state_t state_i,
  input  wire vbt_pkg::in_item_t    item_i,
  output vbt_pkg::beam_state_t      state_o,
  output vbt_pkg::out_item_t        result_o
);
  import vbt_pkg::*;

  logic             line_hit, dot_hit, dot_zero, irq_req, vb_start, rearm;
  logic             hdma_line, frame;
  logic             irq_f, nmi_f, vblank_f;
  logic [DotW-1:0]  dot_inc, dot_nx;
  logic [LineW-1:0] line_inc, line_nx;

  // v_timer = 511 gives 512, which never matches
  assign line_hit = {1'b0, state_i.line_count} == ({1'b0, cfg_i.v_timer} + 10'd1);
  assign dot_hit  = state_i.dot_count == {cfg_i.h_timer, 2'b00};
  assign dot_zero = state_i.dot_count == '0;

  always_comb begin
    if (cfg_i.v_irq_enable && cfg_i.h_irq_enable) begin
      irq_req = line_hit && dot_hit;
    end else if (cfg_i.v_irq_enable) begin
      irq_req = line_hit && (state_i.dot_count == HdmaDot);
    end else if (cfg_i.h_irq_enable) begin
      irq_req = dot_hit;
    end else begin
      irq_req = 1'b0;
    end
  end

  always_comb begin
    irq_f     = (state_i.in_irq && !item_i.clear_irq_flag) || irq_req;
    nmi_f     = state_i.in_nmi && !item_i.clear_nmi_flag;
    vblank_f  = state_i.in_vblank;
    vb_start  = 1'b0;
    rearm     = 1'b0;
    hdma_line = 1'b0;
    if (dot_zero) begin
      if (state_i.line_count == '0) begin
        vblank_f = 1'b0;
        nmi_f    = 1'b0;
        rearm    = 1'b1;
      end else if (state_i.line_count == VblankLine) begin
        vb_start = !cfg_i.overscan_mode;
      end else if (state_i.line_count == VblankLineOvscan) begin
        vb_start = !state_i.in_vblank;
      end
      if (vb_start) begin
        vblank_f = 1'b1;
        nmi_f    = 1'b1;
      end
    end else if (state_i.dot_count == HdmaDot) begin
      hdma_line = !state_i.in_vblank;
    end
  end

  // advance, wrapping at or beyond the line and frame length
  always_comb begin
    dot_inc  = state_i.dot_count + DotStep;
    line_inc = state_i.line_count + LineW'(1);
    dot_nx   = dot_inc;
    line_nx  = state_i.line_count;
    frame    = 1'b0;
    if (dot_inc >= DotsPerLine) begin
      dot_nx  = '0;
      line_nx = line_inc;
      if (line_inc >= LinesPerFrame) begin
        line_nx = '0;
        frame   = 1'b1;
      end
    end
  end

  assign state_o = '{dot_count: dot_nx, line_count: line_nx, in_vblank: vblank_f,
                     in_nmi: nmi_f, in_irq: irq_f};

  assign result_o = '{
    dot_position:       dot_nx,
    line_position:      line_nx,
    irq_request:        irq_req,
    irq_flag:           irq_f,
    nmi_request:        vb_start && cfg_i.nmi_enable,
    nmi_flag:           nmi_f,
    vblank_active:      vblank_f,
    vblank_start_pulse: vb_start,
    hdma_rearm_pulse:   rearm,
    hdma_line_pulse:    hdma_line,
    joy_restart_pulse:  vb_start && cfg_i.auto_joy_enable,
    frame_done:         frame
  };

endmodule
`default_nettype wire

@@ hdl/video_beam_timer_irq_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_beam_timer_irq_unit
// Beam position timer with H/V timer interrupt, NMI and HDMA strobes.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on in_data_i is one two-master-clock tick, carrying the
//   interrupt and NMI flag clears. Each item yields exactly one result item
//   on out_data_o with the position after the tick and the event strobes.
//   Both channels are valid/ready; an item moves on valid && ready.
//   out_valid_o is registered: an accepted item passes the input register,
//   then the result register. Throughput: one item per cycle while the
//   receiver takes results; the beam state is updated as an item passes
//   from the input register to the result register.
//   A stalled receiver holds the result register; the input register still
//   takes one further item, after which in_ready_o drops until out_ready_i.
//   Reset clears position, vblank, NMI and interrupt flags, empties both
//   registers, and loads the timer compares with 511 and all enables off.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   the next edge; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module video_beam_timer_irq_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [vbt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [vbt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire vbt_pkg::in_item_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output vbt_pkg::out_item_t                out_data_o
);
  import vbt_pkg::*;

  cfg_t        cfg;
  beam_state_t state_q, state_nx;
  out_item_t   result, res_q;
  in_item_t    in_q;
  logic        in_vld_q, res_vld_q, advance;

  vbt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vbt_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_nx),
    .result_o (result)
  );

  assign advance    = !res_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= in_vld_q;
        if (in_vld_q) begin
          state_q <= state_nx;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && in_vld_q) begin
      res_q <= result;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule
`default_nettype wire

@@ sim/video_beam_timer_irq_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_beam_timer_irq_unit_test
// Self-checking bench for the beam timer: ticks go in over valid/ready, and
// every result item is checked against a beam model kept in the scoreboard.
// The run covers the first line of a frame, through the HDMA dot.
// ----------------------------------------------------------------------------
module video_beam_timer_irq_unit_test;
  import vbt_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int ShowLimit  = 10;

  class beam_checker;
    cfg_t             cfg;
    logic [DotW-1:0]  dot;
    logic [LineW-1:0] line;
    bit               vblank, nmi_flag, irq_flag;
    out_item_t        beam_results_q[$];
    int               errors;
    int               results_seen;

    function new();
      cfg = '0;
      cfg.v_timer = '1;
      cfg.h_timer = '1;
      dot = '0;
      line = '0;
      vblank = 1'b0;
      nmi_flag = 1'b0;
      irq_flag = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    // one tick of the beam: compare, frame/vblank events, then advance
    function out_item_t advance_beam(in_item_t it);
      out_item_t   r;
      int unsigned d, l;
      bit          line_hit, dot_hit, irq_hit, vb_start;
      r = '0;
      d = dot;
      l = line;
      line_hit = (l == cfg.v_timer + 1);
      dot_hit = (d == 4 * cfg.h_timer);
      if (it.clear_irq_flag) irq_flag = 1'b0;
      if (it.clear_nmi_flag) nmi_flag = 1'b0;
      if (cfg.v_irq_enable && cfg.h_irq_enable) irq_hit = line_hit && dot_hit;
      else if (cfg.v_irq_enable) irq_hit = line_hit && (d == HdmaDot);
      else if (cfg.h_irq_enable) irq_hit = dot_hit;
      else irq_hit = 1'b0;
      if (irq_hit) irq_flag = 1'b1;
      vb_start = 1'b0;
      if (d == 0) begin
        if (l == 0) begin
          vblank = 1'b0;
          nmi_flag = 1'b0;
          r.hdma_rearm_pulse = 1'b1;
        end else if (l == VblankLine) begin
          vb_start = !cfg.overscan_mode;
        end else if (l == VblankLineOvscan) begin
          // already in vblank unless overscan held it off
          vb_start = !vblank;
        end
        if (vb_start) begin
          vblank = 1'b1;
          nmi_flag = 1'b1;
          r.nmi_request = cfg.nmi_enable;
          r.joy_restart_pulse = cfg.auto_joy_enable;
        end
      end else if (d == HdmaDot) begin
        r.hdma_line_pulse = !vblank;
      end
      d = (d + DotStep) % 2048;
      if (d >= DotsPerLine) begin
        d = 0;
        l = (l + 1) % 512;
        if (l >= LinesPerFrame) begin
          l = 0;
          r.frame_done = 1'b1;
        end
      end
      dot = d[DotW-1:0];
      line = l[LineW-1:0];
      r.dot_position = dot;
      r.line_position = line;
      r.irq_request = irq_hit;
      r.irq_flag = irq_flag;
      r.nmi_flag = nmi_flag;
      r.vblank_active = vblank;
      r.vblank_start_pulse = vb_start;
      return r;
    endfunction

    function void note_input(in_item_t it);
      beam_results_q.push_back(advance_beam(it));
    endfunction

    function int pending();
      return beam_results_q.size();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= ShowLimit)
          $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (beam_results_q.size() == 0) begin
        errors++;
        if (errors <= ShowLimit)
          $display("result %0d arrived with nothing outstanding", results_seen);
        return;
      end
      want = beam_results_q.pop_front();
      compare_field("dot_position", want.dot_position, got.dot_position);
      compare_field("line_position", want.line_position, got.line_position);
      compare_field("irq_request", want.irq_request, got.irq_request);
      compare_field("irq_flag", want.irq_flag, got.irq_flag);
      compare_field("nmi_request", want.nmi_request, got.nmi_request);
      compare_field("nmi_flag", want.nmi_flag, got.nmi_flag);
      compare_field("vblank_active", want.vblank_active, got.vblank_active);
      compare_field("vblank_start_pulse", want.vblank_start_pulse, got.vblank_start_pulse);
      compare_field("hdma_rearm_pulse", want.hdma_rearm_pulse, got.hdma_rearm_pulse);
      compare_field("hdma_line_pulse", want.hdma_line_pulse, got.hdma_line_pulse);
      compare_field("joy_restart_pulse", want.joy_restart_pulse, got.joy_restart_pulse);
      compare_field("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  in_item_t            in_data = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  out_item_t           out_data;

  int  send_idle_pct = 21;
  int  recv_idle_pct = 77;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;

  beam_checker tally = new();

  video_beam_timer_irq_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check on handshake, then pick next ready (long hold on request)
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tally.check_result(out_data);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tally.note_input(it);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic in_item_t rand_item(int clear_pct);
    in_item_t it;
    it.clear_irq_flag = ($urandom_range(99) < clear_pct);
    it.clear_nmi_flag = ($urandom_range(99) < clear_pct);
    return it;
  endfunction

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tally.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    logic [7:0] pad;
    drain();
    // unused upper bits of the 1-bit registers carry noise
    pad = 8'($urandom);
    write_reg(RegVIrqEn, {pad, c.v_irq_enable});
    pad = 8'($urandom);
    write_reg(RegHIrqEn, {pad, c.h_irq_enable});
    write_reg(RegVTimer, c.v_timer);
    write_reg(RegHTimer, c.h_timer);
    pad = 8'($urandom);
    write_reg(RegNmiEn, {pad, c.nmi_enable});
    pad = 8'($urandom);
    write_reg(RegAutoJoy, {pad, c.auto_joy_enable});
    pad = 8'($urandom);
    write_reg(RegOverscan, {pad, c.overscan_mode});
    cfg_we <= 1'b0;
    @(posedge clk);
    tally.cfg = c;
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 3) hold_req = 1'b1;
      if (k == (2 * n) / 3) drain();
      send_item(rand_item(15));
      idle_gap();
    end
  endtask

  task automatic run_back_to_back(input int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 4) hold_req = 1'b1;
      send_item(rand_item(12));
      idle_gap();
    end
  endtask

  initial begin : stimulus
    cfg_t     c;
    in_item_t it;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dot-0 compare right after reset, all clear combinations
    c = tally.cfg;
    c.h_irq_enable = 1'b1;
    c.h_timer = '0;
    apply_cfg(c);
    for (int i = 0; i < 20; i++) begin
      it.clear_irq_flag = i[0];
      it.clear_nmi_flag = i[1];
      send_item(it);
      idle_gap();
    end

    // dot compare somewhere ahead of the beam on line 0
    c = '0;
    c.h_irq_enable = 1'b1;
    c.h_timer = 9'($urandom_range(10, 89));
    c.nmi_enable = 1'($urandom);
    c.auto_joy_enable = 1'($urandom);
    apply_cfg(c);
    run_random(160);

    // both compares on: a dot hit alone must not fire
    send_idle_pct = 77;
    recv_idle_pct = 21;
    c = '1;
    c.h_timer = 9'($urandom_range(90, 169));
    apply_cfg(c);
    run_random(160);

    // back to back from here: dot compare and HDMA strobe at dot 1024
    send_idle_pct = 0;
    recv_idle_pct = 0;
    c = '0;
    c.h_irq_enable = 1'b1;
    c.h_timer = 9'd256;
    c.nmi_enable = 1'b1;
    c.auto_joy_enable = 1'b1;
    apply_cfg(c);
    run_back_to_back(180);

    drain();
    repeat (8) @(posedge clk);
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
